[src/glcd_pkg.sv]
// shared types, constants and glyph table for the glyph column writer
// no dependencies; compiled first
package glcd_pkg;

    localparam int GLYPH_COLUMNS = 8;
    localparam int GLYPH_COUNT   = 16;

    localparam logic [2:0] LAST_IDX       = 3'(GLYPH_COLUMNS - 1);
    localparam logic [5:0] LAST_COLUMN    = 6'd63;
    localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;
    localparam logic [7:0] CMD_SET_COLUMN = 8'h40;

    // character codes of the digit range bounds and of the drawn symbols
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_EQ    = 8'h3D;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;

    localparam logic [3:0] GL_DOT   = 4'd10;
    localparam logic [3:0] GL_EQ    = 4'd11;
    localparam logic [3:0] GL_PLUS  = 4'd12;
    localparam logic [3:0] GL_MINUS = 4'd13;
    localparam logic [3:0] GL_STAR  = 4'd14;
    localparam logic [3:0] GL_SLASH = 4'd15;

    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][8] = '{
        '{8'h00, 8'h00, 8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h42, 8'h7f, 8'h40, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h00},
        '{8'h00, 8'h00, 8'h21, 8'h41, 8'h45, 8'h4b, 8'h32, 8'h00},
        '{8'h00, 8'h00, 8'h18, 8'h14, 8'h12, 8'h7f, 8'h10, 8'h00},
        '{8'h00, 8'h00, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00},
        '{8'h00, 8'h00, 8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30, 8'h00},
        '{8'h00, 8'h00, 8'h01, 8'h01, 8'h71, 8'h0d, 8'h03, 8'h00},
        '{8'h00, 8'h00, 8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00},
        '{8'h00, 8'h00, 8'h06, 8'h49, 8'h49, 8'h29, 8'h1e, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h00},
        '{8'h00, 8'h00, 8'h08, 8'h08, 8'h3e, 8'h08, 8'h08, 8'h00},
        '{8'h00, 8'h00, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h00},
        '{8'h00, 8'h00, 8'h22, 8'h14, 8'h08, 8'h14, 8'h22, 8'h00},
        '{8'h00, 8'h00, 8'h08, 8'h08, 8'h2a, 8'h08, 8'h08, 8'h00}
    };

    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAGE,
        PH_COLUMN
    } t_phase;

    typedef struct packed {
        logic [3:0] glyph;
        logic [2:0] col_idx;
        t_phase     phase;
        logic [2:0] page;
        logic [5:0] column;
    } t_step_state;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_byte;
        logic       last;
    } t_wr;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_glyph_sel;

    function automatic logic [7:0] flip_bits(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = b[7 - k];
        end
        return r;
    endfunction

    function automatic t_glyph_sel glyph_of(input logic [7:0] c);
        t_glyph_sel s;
        s.hit = 1'b1;
        s.idx = '0;
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
            s.idx = 4'(c - CHR_ZERO);
        end else begin
            case (c)
                CHR_DOT:   s.idx = GL_DOT;
                CHR_EQ:    s.idx = GL_EQ;
                CHR_PLUS:  s.idx = GL_PLUS;
                CHR_MINUS: s.idx = GL_MINUS;
                CHR_STAR:  s.idx = GL_STAR;
                CHR_SLASH: s.idx = GL_SLASH;
                default:   s.hit = 1'b0;
            endcase
        end
        return s;
    endfunction

endpackage

[src/glcd_char_if.sv]
// character input channel: valid/ready handshake with an ascii code
// no dependencies
interface glcd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

[src/glcd_wr_if.sv]
// bus write output channel: valid/ready handshake with one lcd bus write
// no dependencies
interface glcd_wr_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last;

    modport source (output valid, output reg_select, output bus_byte, output last, input ready);
    modport sink   (input valid, input reg_select, input bus_byte, input last, output ready);
endinterface

[src/glcd_step.sv]
// one bus write of the sequencer: from the current cursor state gives the write
// and the state after it; depends on glcd_pkg
module glcd_step
    import glcd_pkg::*;
(
    input  t_step_state i_st,
    output t_step_state o_st,
    output t_wr         o_wr
);

    always_comb begin
        o_st            = i_st;
        o_wr.reg_select = 1'b0;
        o_wr.bus_byte   = '0;
        o_wr.last       = 1'b0;
        case (i_st.phase)
            PH_DATA: begin
                o_wr.reg_select = 1'b1;
                o_wr.bus_byte   = flip_bits(GLYPH_ROM[i_st.glyph][i_st.col_idx]);
                if (i_st.column == LAST_COLUMN) begin
                    // end of line: move to next page, commands follow
                    o_st.page   = i_st.page + 3'd1;
                    o_st.column = '0;
                    o_st.phase  = PH_PAGE;
                end else begin
                    o_st.column  = i_st.column + 6'd1;
                    o_st.col_idx = i_st.col_idx + 3'd1;
                    o_wr.last    = (i_st.col_idx == LAST_IDX);
                end
            end
            PH_PAGE: begin
                o_wr.bus_byte = flip_bits(CMD_SET_PAGE | {5'b0, i_st.page});
                o_st.phase    = PH_COLUMN;
            end
            PH_COLUMN: begin
                o_wr.bus_byte = flip_bits(CMD_SET_COLUMN | {2'b0, i_st.column});
                o_st.phase    = PH_DATA;
                o_st.col_idx  = i_st.col_idx + 3'd1;
                o_wr.last     = (i_st.col_idx == LAST_IDX);
            end
            default: begin
                o_st.phase = PH_DATA;
            end
        endcase
    end

endmodule

[src/glcd_glyph_column_writer_core.sv]
// top level of the glyph column writer: character register, write sequencer
// and output register; depends on glcd_pkg, glcd_char_if, glcd_wr_if, glcd_step
//
// usage
//   i_char : one ascii code per transfer; digits and . = + - * / are drawn,
//            any other code is taken and gives no write
//   o_wr   : one lcd bus write per transfer (reg_select 1 data, 0 command),
//            bytes already bit-reversed; last marks the final write of a character
// a character's first write passes the character register, then the output register
// throughput: one bus write per cycle while o_wr.ready is high, so 8 writes per
//   character, or 10 when the glyph crosses the last column and the set page /
//   set column commands are inserted; the character register takes the next code in
//   the same cycle the current one moves its last write into the output register
// reset: page and column cursors go to the first page and column, nothing is
//   pending and the output channel is empty
// stall: while o_wr.ready is low the held write stays on the port, the
//   sequencer does not advance and i_char.ready drops once a character waits
module glcd_glyph_column_writer_core
    import glcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    glcd_char_if.sink i_char,
    glcd_wr_if.source o_wr
);

    // character register and cursors
    logic        r_busy;
    t_step_state r_st;
    logic        n_busy;
    t_step_state n_st;

    // output register
    logic        r_out_valid;
    t_wr         r_out;
    logic        n_out_valid;
    t_wr         n_out;

    t_step_state step_st;
    t_wr         step_wr;
    t_glyph_sel  sel;
    logic        step;
    logic        load;

    glcd_step u_step (
        .i_st (r_st),
        .o_st (step_st),
        .o_wr (step_wr)
    );

    assign sel = glyph_of(i_char.char_code);

    // a write moves forward when the output register is free or being emptied
    assign step         = r_busy && (!r_out_valid || o_wr.ready);
    assign i_char.ready = !r_busy || (step && step_wr.last);
    assign load         = i_char.valid && i_char.ready && sel.hit;

    always_comb begin
        n_st        = step ? step_st : r_st;
        n_busy      = r_busy && !(step && step_wr.last);
        n_out       = step ? step_wr : r_out;
        n_out_valid = step || (r_out_valid && !o_wr.ready);
        if (load) begin
            // cursors carry over from the previous character
            n_busy       = 1'b1;
            n_st.glyph   = sel.idx;
            n_st.col_idx = '0;
            n_st.phase   = PH_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_st        <= '{glyph: '0, col_idx: '0, phase: PH_DATA, page: '0, column: '0};
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_wr.valid      = r_out_valid;
    assign o_wr.reg_select = r_out.reg_select;
    assign o_wr.bus_byte   = r_out.bus_byte;
    assign o_wr.last       = r_out.last;

`ifndef SYNTHESIS
    // the set page command is always followed by the set column command
    a_page_then_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_st.phase == PH_PAGE) |=> (r_st.phase == PH_COLUMN))
        else $error("set page not followed by set column");

    // during the command pair the column cursor sits at the first column
    a_cmd_column_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase != PH_DATA) |-> (r_st.column == '0))
        else $error("column cursor not cleared at line wrap");

    // a drawn character always leaves work pending
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_busy)
        else $error("recognised character dropped");

    // a new character is never taken while the current one still has writes
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !(step && step_wr.last)) |-> !i_char.ready)
        else $error("character accepted during sequence");
`endif

endmodule
